// File: design/crrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crrd_pkg;

  // Map geometry and coordinate packing of the area registers.
  localparam int MAP_WIDTH  = 128;
  localparam int MAP_HEIGHT = 128;
  localparam int COORD_BITS = 12;

  // Field widths fixed by the interface.
  localparam int POS_W     = 12;
  localparam int COLOR_W   = 8;
  localparam int CNT_W     = 15;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int RAD_W     = 12;
  localparam int PCT_W     = 7;

  // Derived widths.
  localparam int CW     = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
  localparam int ROW_W  = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int COL_W  = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int SQ_W   = 2 * CW;
  localparam int DIST_W = SQ_W + 1;
  localparam int PROD_W = CNT_W + PCT_W;

  localparam logic [PCT_W-1:0] PERCENT_SCALE = PCT_W'(100);
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  localparam logic ACT_PIXEL     = 1'b0;
  localparam logic ACT_QUERY     = 1'b1;
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_QUERY    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MIN,
    REG_COLOR_MAX,
    REG_AREA_TL,
    REG_AREA_BR,
    REG_CIRCLE_CENTER,
    REG_CIRCLE_RADIUS,
    REG_DETECT_PERCENT,
    REG_GRAY_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic               action;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic             detected;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] area_count;
    logic             out_of_area;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic calc;
    logic update;
    logic mul;
    logic load_query;
    logic load_dec;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_busy;
    logic is_query;
    logic frame_end;
  } dp_status_t;

  function automatic logic [COORD_BITS-1:0] coord_x(input logic [CFG_W-1:0] v);
    coord_x = v[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] coord_y(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] s;
    s = v >> COORD_BITS;
    coord_y = s[COORD_BITS-1:0];
  endfunction

  function automatic logic chan_ok(input logic [COLOR_W-1:0] c,
                                   input logic [COLOR_W-1:0] lo,
                                   input logic [COLOR_W-1:0] hi);
    chan_ok = (c >= lo) && (c <= hi);
  endfunction

endpackage

`default_nettype wire

// File: design/crrd_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Hit map: one row of MAP_WIDTH bits per address, bit-granular writes,
// registered row reads, and a row-per-cycle clearing sweep.
module crrd_map (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clr_start,
  output logic                                clr_busy,
  input  wire logic                           wr_en,
  input  wire logic [crrd_pkg::ROW_W-1:0]     wr_row,
  input  wire logic [crrd_pkg::COL_W-1:0]     wr_col,
  input  wire logic                           wr_bit,
  input  wire logic                           rd_en,
  input  wire logic [crrd_pkg::ROW_W-1:0]     rd_row,
  output logic [crrd_pkg::MAP_WIDTH-1:0]      rd_data
);

  logic [crrd_pkg::MAP_WIDTH-1:0] mem_r [crrd_pkg::MAP_HEIGHT];
  logic [crrd_pkg::MAP_WIDTH-1:0] rd_data_r;
  logic                           clr_active_r, clr_active_nxt;
  logic [crrd_pkg::ROW_W-1:0]     clr_row_r, clr_row_nxt;
  logic                           clr_last;

  assign clr_last = (clr_row_r == crrd_pkg::ROW_W'(crrd_pkg::MAP_HEIGHT - 1));

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_row_nxt    = clr_row_r;
    if (clr_start) begin
      clr_active_nxt = 1'b1;
      clr_row_nxt    = '0;
    end else if (clr_active_r) begin
      clr_active_nxt = !clr_last;
      clr_row_nxt    = clr_row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_row_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_row_r    <= clr_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem_r[clr_row_r] <= '0;
    end else if (wr_en) begin
      mem_r[wr_row][wr_col] <= wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  assign clr_busy = clr_active_r;
  assign rd_data  = rd_data_r;

endmodule

`default_nettype wire

// File: design/crrd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module crrd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire crrd_pkg::in_item_t             in_data,
  output crrd_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [crrd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [crrd_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire crrd_pkg::dp_cmd_t              cmd,
  output crrd_pkg::dp_status_t                status
);

  // Configuration registers.
  logic [crrd_pkg::CFG_W-1:0] color_min_r, color_max_r, area_tl_r, area_br_r, center_r;
  logic [crrd_pkg::RAD_W-1:0] radius_r;
  logic [crrd_pkg::PCT_W-1:0] percent_r;
  logic                       gray_r;
  logic                       area_change;

  // Item and stage registers.
  crrd_pkg::in_item_t         item_r;
  logic                       in_rect_r, in_rect_nxt;
  logic                       slot_ok_r, slot_ok_nxt;
  logic                       color_ok_r, color_ok_nxt;
  logic [crrd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [crrd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [crrd_pkg::SQ_W-1:0]  sqx_r, sqx_nxt, sqy_r, sqy_nxt, r2_r, r2_nxt;
  logic [crrd_pkg::CNT_W-1:0] hit_cnt_r, hit_cnt_nxt, area_cnt_r, area_cnt_nxt;
  logic [crrd_pkg::PROD_W-1:0] prod_hit_r, prod_area_r;
  crrd_pkg::out_item_t        out_item_r, out_item_nxt;

  logic [crrd_pkg::CW-1:0]    x, y, tlx, tly, brx, bry, cx, cy, ux, uy, adx, ady;
  logic [crrd_pkg::DIST_W-1:0] dist_sq;
  logic                       hit;
  logic                       det;
  logic [crrd_pkg::MAP_WIDTH-1:0] map_row;
  logic                       map_busy;

  assign area_change = cfg_we &&
                       ((cfg_idx == crrd_pkg::REG_AREA_TL) ||
                        (cfg_idx == crrd_pkg::REG_AREA_BR));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_min_r <= '0;
      color_max_r <= '0;
      area_tl_r   <= '0;
      area_br_r   <= '0;
      center_r    <= '0;
      radius_r    <= '0;
      percent_r   <= '0;
      gray_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        crrd_pkg::REG_COLOR_MIN:      color_min_r <= cfg_wdata;
        crrd_pkg::REG_COLOR_MAX:      color_max_r <= cfg_wdata;
        crrd_pkg::REG_AREA_TL:        area_tl_r   <= cfg_wdata;
        crrd_pkg::REG_AREA_BR:        area_br_r   <= cfg_wdata;
        crrd_pkg::REG_CIRCLE_CENTER:  center_r    <= cfg_wdata;
        crrd_pkg::REG_CIRCLE_RADIUS:  radius_r    <= cfg_wdata[crrd_pkg::RAD_W-1:0];
        crrd_pkg::REG_DETECT_PERCENT: percent_r   <= cfg_wdata[crrd_pkg::PCT_W-1:0];
        crrd_pkg::REG_GRAY_MODE:      gray_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Geometry and color classification of the captured item.
  always_comb begin
    x   = crrd_pkg::CW'(item_r.pos_x);
    y   = crrd_pkg::CW'(item_r.pos_y);
    tlx = crrd_pkg::CW'(crrd_pkg::coord_x(area_tl_r));
    tly = crrd_pkg::CW'(crrd_pkg::coord_y(area_tl_r));
    brx = crrd_pkg::CW'(crrd_pkg::coord_x(area_br_r));
    bry = crrd_pkg::CW'(crrd_pkg::coord_y(area_br_r));
    cx  = crrd_pkg::CW'(crrd_pkg::coord_x(center_r));
    cy  = crrd_pkg::CW'(crrd_pkg::coord_y(center_r));
    ux  = x - tlx;
    uy  = y - tly;
    adx = (x >= cx) ? (x - cx) : (cx - x);
    ady = (y >= cy) ? (y - cy) : (cy - y);

    in_rect_nxt = (x >= tlx) && (x < brx) && (y >= tly) && (y < bry);
    slot_ok_nxt = in_rect_nxt &&
                  ({1'b0, ux} < (crrd_pkg::CW + 1)'(crrd_pkg::MAP_WIDTH)) &&
                  ({1'b0, uy} < (crrd_pkg::CW + 1)'(crrd_pkg::MAP_HEIGHT));
    row_nxt = uy[crrd_pkg::ROW_W-1:0];
    col_nxt = ux[crrd_pkg::COL_W-1:0];

    color_ok_nxt = crrd_pkg::chan_ok(item_r.red, color_min_r[7:0], color_max_r[7:0]) &&
                   (gray_r ||
                    (crrd_pkg::chan_ok(item_r.green, color_min_r[15:8], color_max_r[15:8]) &&
                     crrd_pkg::chan_ok(item_r.blue, color_min_r[23:16], color_max_r[23:16])));

    sqx_nxt = crrd_pkg::SQ_W'(adx) * crrd_pkg::SQ_W'(adx);
    sqy_nxt = crrd_pkg::SQ_W'(ady) * crrd_pkg::SQ_W'(ady);
    r2_nxt  = crrd_pkg::SQ_W'(radius_r) * crrd_pkg::SQ_W'(radius_r);
  end

  // Hit decision and saturating counters.
  always_comb begin
    dist_sq = crrd_pkg::DIST_W'(sqx_r) + crrd_pkg::DIST_W'(sqy_r);
    hit     = in_rect_r && color_ok_r && (dist_sq <= crrd_pkg::DIST_W'(r2_r));

    hit_cnt_nxt  = hit_cnt_r;
    area_cnt_nxt = area_cnt_r;
    if (cmd.load_dec) begin
      hit_cnt_nxt  = '0;
      area_cnt_nxt = '0;
    end else if (cmd.update && in_rect_r) begin
      if (area_cnt_r != crrd_pkg::CNT_MAX) begin
        area_cnt_nxt = area_cnt_r + 1'b1;
      end
      if (hit && (hit_cnt_r != crrd_pkg::CNT_MAX)) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end
    end
  end

  // floor(hits*100/area) >= percent is the same test as hits*100 >= percent*area.
  always_comb begin
    if ((percent_r != '0) && (hit_cnt_r != '0) && (area_cnt_r != '0)) begin
      det = (prod_hit_r >= prod_area_r);
    end else begin
      det = (hit_cnt_r != '0);
    end

    out_item_nxt = out_item_r;
    if (cmd.load_query) begin
      out_item_nxt.result_kind = crrd_pkg::KIND_QUERY;
      out_item_nxt.detected    = slot_ok_r && map_row[col_r];
      out_item_nxt.hit_count   = '0;
      out_item_nxt.area_count  = '0;
      out_item_nxt.out_of_area = !slot_ok_r;
    end else if (cmd.load_dec) begin
      out_item_nxt.result_kind = crrd_pkg::KIND_DECISION;
      out_item_nxt.detected    = det;
      out_item_nxt.hit_count   = hit_cnt_r;
      out_item_nxt.area_count  = area_cnt_r;
      out_item_nxt.out_of_area = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      area_cnt_r <= '0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      area_cnt_r <= area_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.calc) begin
      in_rect_r  <= in_rect_nxt;
      slot_ok_r  <= slot_ok_nxt;
      color_ok_r <= color_ok_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      sqx_r      <= sqx_nxt;
      sqy_r      <= sqy_nxt;
      r2_r       <= r2_nxt;
    end
    if (cmd.mul) begin
      prod_hit_r  <= crrd_pkg::PROD_W'(hit_cnt_r) * crrd_pkg::PROD_W'(crrd_pkg::PERCENT_SCALE);
      prod_area_r <= crrd_pkg::PROD_W'(percent_r) * crrd_pkg::PROD_W'(area_cnt_r);
    end
    out_item_r <= out_item_nxt;
  end

  crrd_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (area_change),
    .clr_busy  (map_busy),
    .wr_en     (cmd.update && slot_ok_r),
    .wr_row    (row_r),
    .wr_col    (col_r),
    .wr_bit    (hit),
    .rd_en     (cmd.calc),
    .rd_row    (row_nxt),
    .rd_data   (map_row)
  );

  assign status.clr_busy  = map_busy;
  assign status.is_query  = (item_r.action == crrd_pkg::ACT_QUERY);
  assign status.frame_end = item_r.frame_end;
  assign out_data         = out_item_r;

endmodule

`default_nettype wire

// File: design/crrd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crrd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire crrd_pkg::dp_status_t status,
  output crrd_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_UPD,
    S_MUL,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !status.clr_busy;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (status.is_query) begin
          state_nxt = S_RESP;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = status.frame_end ? S_MUL : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.load_query = status.is_query;
          cmd.load_dec   = !status.is_query;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CALC))
    else $error("accepted item did not enter the calculation step");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_query || cmd.load_dec) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire

// File: design/color_range_region_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Color range region detector. Pixels (action 0) inside the configured
// rectangle are counted; a counted pixel is a hit when it also lies inside
// the circle (dx*dx + dy*dy <= r*r) and its tested channels lie within
// their min..max bounds (red only in gray mode). Each classified pixel
// inside the map window writes its hit or miss to a MAP_WIDTH x MAP_HEIGHT
// bit map anchored at the rectangle's top-left corner. The pixel with
// frame_end set produces a decision transfer carrying both counts, after
// which the counters clear. A query (action 1) returns the stored map bit
// at a position, or zero with out_of_area set outside the rectangle or the
// map. Items are processed one at a time by a controller state machine:
// a plain pixel passes the capture, calc and update states, a query adds
// the response state and a frame-end pixel the multiply and response
// states; the response state waits until the previous result is taken. The
// decision uses two 15x7 multiplies (hits*100 against percent*count), so
// no divider is involved. After reset and after every write to either
// area register the map is cleared by a sweep of one row per cycle, which
// holds in_ready low until all MAP_HEIGHT (128) rows are clear; configuration
// writes are taken at any time and must only be issued while the block is idle.
module color_range_region_detector_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire crrd_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output crrd_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire logic [crrd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [crrd_pkg::CFG_W-1:0]     cfg_wdata
);

  // Command and status bundles between the sequencer and the datapath.
  crrd_pkg::dp_cmd_t    cmd;
  crrd_pkg::dp_status_t status;

  crrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the counters, the hit map and
  // the output register, so a finished result can wait for its transfer
  // while the next item is already being accepted.
  crrd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: tb/sv/color_range_region_detector_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the color range region detector. Every accepted
// transfer on the input channel is run through a behavioral copy of the
// detector that lives in this module; the outcome (a frame decision or a map
// query answer) is queued and compared field by field with the next result
// transfer that the block hands out.
module color_range_region_detector_core_tb;

  localparam int MAP_BITS    = crrd_pkg::MAP_WIDTH * crrd_pkg::MAP_HEIGHT;
  // Longest stretch without any transfer: the map sweep, the long receiver
  // hold and the sender gaps all fit well inside this.
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  // Drain margin after the last result: long enough for the block to finish
  // any item still in flight, so it is idle before registers change.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  crrd_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  crrd_pkg::out_item_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [crrd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [crrd_pkg::CFG_W-1:0]     cfg_wdata = '0;

  color_range_region_detector_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behavioral copy of the detector. The register mirror is updated at the
  // edge that takes each write, the map and counters at each accepted
  // input transfer, in the order the block sees them.
  // ---------------------------------------------------------------------
  logic [crrd_pkg::CFG_W-1:0] lo_bounds = '0;
  logic [crrd_pkg::CFG_W-1:0] hi_bounds = '0;
  logic [crrd_pkg::CFG_W-1:0] rect_tl = '0;
  logic [crrd_pkg::CFG_W-1:0] rect_br = '0;
  logic [crrd_pkg::CFG_W-1:0] circle_ctr = '0;
  logic [crrd_pkg::RAD_W-1:0] circle_rad = '0;
  logic [crrd_pkg::PCT_W-1:0] hit_pct = '0;
  logic                       gray_only = 1'b0;
  bit                         hit_bits [MAP_BITS];
  logic [crrd_pkg::CNT_W-1:0] frame_hits = '0;
  logic [crrd_pkg::CNT_W-1:0] frame_pixels = '0;

  crrd_pkg::out_item_t pending_results [$];
  int                  mismatches = 0;

  // Packed area registers keep x in the low COORD_BITS bits and y above it.
  function automatic int col_of(logic [crrd_pkg::CFG_W-1:0] v);
    return int'(v[crrd_pkg::COORD_BITS-1:0]);
  endfunction

  function automatic int row_of(logic [crrd_pkg::CFG_W-1:0] v);
    return int'(v[2*crrd_pkg::COORD_BITS-1:crrd_pkg::COORD_BITS]);
  endfunction

  function automatic logic [crrd_pkg::CFG_W-1:0] place(int x, int y);
    return crrd_pkg::CFG_W'((y << crrd_pkg::COORD_BITS) | x);
  endfunction

  function automatic bit in_rect(int x, int y);
    return x >= col_of(rect_tl) && x < col_of(rect_br) &&
           y >= row_of(rect_tl) && y < row_of(rect_br);
  endfunction

  // The map is anchored at the top-left corner; positions past its width or
  // height are classified but never stored.
  function automatic bit map_slot(int x, int y, output int slot);
    int ux, uy;
    ux = x - col_of(rect_tl);
    uy = y - row_of(rect_tl);
    slot = 0;
    if (ux >= crrd_pkg::MAP_WIDTH || uy >= crrd_pkg::MAP_HEIGHT) return 1'b0;
    slot = uy * crrd_pkg::MAP_WIDTH + ux;
    return 1'b1;
  endfunction

  function automatic bit chan_match(logic [crrd_pkg::COLOR_W-1:0] c, int sh);
    return c >= lo_bounds[sh +: crrd_pkg::COLOR_W] && c <= hi_bounds[sh +: crrd_pkg::COLOR_W];
  endfunction

  function automatic bit in_circle(int x, int y);
    int dx, dy, r;
    dx = x - col_of(circle_ctr);
    dy = y - row_of(circle_ctr);
    r  = int'(circle_rad);
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic logic [crrd_pkg::CNT_W-1:0] sat_inc(logic [crrd_pkg::CNT_W-1:0] v);
    return (v == crrd_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Applies one input item to the behavioral state. Returns 1 when the item
  // produces a result transfer, which is then left in res.
  function automatic bit classify_item(input crrd_pkg::in_item_t it,
                                       output crrd_pkg::out_item_t res);
    int x, y, slot;
    bit mapped, hit;
    x = int'(it.pos_x);
    y = int'(it.pos_y);
    res = '0;
    slot = 0;
    if (it.action == crrd_pkg::ACT_QUERY) begin
      mapped = 1'b0;
      if (in_rect(x, y)) mapped = map_slot(x, y, slot);
      res.result_kind = crrd_pkg::KIND_QUERY;
      res.detected    = mapped ? hit_bits[slot] : 1'b0;
      res.out_of_area = !mapped;
      return 1'b1;
    end
    if (in_rect(x, y)) begin
      hit = in_circle(x, y) && chan_match(it.red, 0) &&
            (gray_only || (chan_match(it.green, 8) && chan_match(it.blue, 16)));
      frame_pixels = sat_inc(frame_pixels);
      if (hit) frame_hits = sat_inc(frame_hits);
      if (map_slot(x, y, slot)) hit_bits[slot] = hit;
    end
    if (!it.frame_end) return 1'b0;
    res.result_kind = crrd_pkg::KIND_DECISION;
    // Integer percentage with truncation, compared against the threshold.
    if (hit_pct != '0 && frame_hits != '0 && frame_pixels != '0)
      res.detected = (int'(frame_hits) * int'(crrd_pkg::PERCENT_SCALE)) / int'(frame_pixels)
                     >= int'(hit_pct);
    else
      res.detected = frame_hits != '0;
    res.hit_count  = frame_hits;
    res.area_count = frame_pixels;
    frame_hits   = '0;
    frame_pixels = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration writes. The caller marks the final write of a sequence so
  // that the write enable drops exactly once.
  // ---------------------------------------------------------------------
  task automatic write_reg(input crrd_pkg::cfg_reg_t idx,
                           input logic [crrd_pkg::CFG_W-1:0] value, input bit last);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      crrd_pkg::REG_COLOR_MIN:      lo_bounds = value;
      crrd_pkg::REG_COLOR_MAX:      hi_bounds = value;
      crrd_pkg::REG_AREA_TL: begin
        rect_tl  = value;
        hit_bits = '{default: 1'b0};
      end
      crrd_pkg::REG_AREA_BR: begin
        rect_br  = value;
        hit_bits = '{default: 1'b0};
      end
      crrd_pkg::REG_CIRCLE_CENTER:  circle_ctr = value;
      crrd_pkg::REG_CIRCLE_RADIUS:  circle_rad = value[crrd_pkg::RAD_W-1:0];
      crrd_pkg::REG_DETECT_PERCENT: hit_pct = value[crrd_pkg::PCT_W-1:0];
      crrd_pkg::REG_GRAY_MODE:      gray_only = value[0];
      default: ;
    endcase
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input logic [crrd_pkg::CFG_W-1:0] lo,
                               input logic [crrd_pkg::CFG_W-1:0] hi,
                               input logic [crrd_pkg::CFG_W-1:0] tl,
                               input logic [crrd_pkg::CFG_W-1:0] br,
                               input logic [crrd_pkg::CFG_W-1:0] ctr, input int rad,
                               input int pct, input bit gray);
    write_reg(crrd_pkg::REG_COLOR_MIN, lo, 1'b0);
    write_reg(crrd_pkg::REG_COLOR_MAX, hi, 1'b0);
    write_reg(crrd_pkg::REG_AREA_TL, tl, 1'b0);
    write_reg(crrd_pkg::REG_AREA_BR, br, 1'b0);
    write_reg(crrd_pkg::REG_CIRCLE_CENTER, ctr, 1'b0);
    write_reg(crrd_pkg::REG_CIRCLE_RADIUS, crrd_pkg::CFG_W'(rad), 1'b0);
    write_reg(crrd_pkg::REG_DETECT_PERCENT, crrd_pkg::CFG_W'(pct), 1'b0);
    write_reg(crrd_pkg::REG_GRAY_MODE, crrd_pkg::CFG_W'(gray), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Input side. The sender offers items in bursts of random length and
  // leaves random gaps between bursts. Valid stays up across a burst.
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(input crrd_pkg::in_item_t it);
    crrd_pkg::out_item_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(1, 12);
        default: gap = $urandom_range(0, 1);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (classify_item(it, res)) pending_results.push_back(res);
  endtask

  // Stops offering, waits for every outstanding result and then lets the
  // block finish any plain pixel that produces no result.
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic crrd_pkg::in_item_t pixel(int x, int y, int r, int g, int b, bit last);
    crrd_pkg::in_item_t it;
    it.action    = crrd_pkg::ACT_PIXEL;
    it.red       = crrd_pkg::COLOR_W'(r);
    it.green     = crrd_pkg::COLOR_W'(g);
    it.blue      = crrd_pkg::COLOR_W'(b);
    it.pos_x     = crrd_pkg::POS_W'(x);
    it.pos_y     = crrd_pkg::POS_W'(y);
    it.frame_end = last;
    return it;
  endfunction

  // Colors and frame_end of a query are don't-care, so they are random.
  function automatic crrd_pkg::in_item_t query(int x, int y);
    crrd_pkg::in_item_t it;
    it = pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 1));
    it.action = crrd_pkg::ACT_QUERY;
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Result side. The receiver switches between stall patterns at random
  // intervals; on request it holds off completely for a long stretch.
  // ---------------------------------------------------------------------
  bit hold_request = 1'b0;

  initial begin : result_sink
    sink_mode_t mode;
    int left;
    mode = SINK_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= (left % 5 != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Each result transfer is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    crrd_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("detected", want.detected, out_data.detected);
        check_field("hit_count", want.hit_count, out_data.hit_count);
        check_field("area_count", want.area_count, out_data.area_count);
        check_field("out_of_area", want.out_of_area, out_data.out_of_area);
      end
    end
  end

  // Watchdog: the run is declared hung when quiet_cycles, the run of cycles
  // with no transfer of any kind, reaches STALL_LIMIT.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Straight out of reset the rectangle is empty: nothing is counted and
  // every query lands outside the area.
  task automatic test_reset_state();
    send_item(pixel(0, 0, 0, 0, 0, 1'b1));
    send_item(query(0, 0));
    settle();
  endtask

  // Rectangle wider than the map, circle of radius 10, channel bounds
  // hit exactly at their edges and just beyond them.
  task automatic test_classification();
    load_settings(24'h0A141E, 24'h6E7882, place(10, 20), place(200, 150),
                  place(40, 50), 10, 0, 1'b0);
    send_item(pixel(40, 50, 30, 20, 10, 1'b0));     // all lower bounds
    send_item(pixel(50, 50, 130, 120, 110, 1'b0));  // upper bounds, on the circle
    send_item(pixel(51, 50, 60, 60, 60, 1'b0));     // just outside the circle
    send_item(pixel(40, 51, 29, 60, 60, 1'b0));     // red below its minimum
    send_item(pixel(40, 52, 60, 60, 111, 1'b0));    // blue above its maximum
    send_item(pixel(9, 50, 60, 60, 60, 1'b0));      // left of the rectangle
    send_item(pixel(150, 50, 60, 60, 60, 1'b0));    // counted, past the map
    send_item(pixel(199, 149, 255, 0, 255, 1'b1));  // last inside position
    send_item(query(40, 50));
    send_item(query(51, 50));
    send_item(query(150, 50));
    send_item(query(200, 50));
    send_item(query(10, 19));
    settle();
  endtask

  // Gray mode ignores green and blue; the threshold is probed below, at
  // and above what a full frame of hits can reach.
  task automatic test_gray_and_percent();
    write_reg(crrd_pkg::REG_GRAY_MODE, crrd_pkg::CFG_W'(1), 1'b0);
    write_reg(crrd_pkg::REG_DETECT_PERCENT, crrd_pkg::CFG_W'(50), 1'b1);
    send_item(pixel(40, 50, 30, 255, 0, 1'b0));
    send_item(pixel(41, 50, 255, 0, 0, 1'b0));
    send_item(pixel(42, 50, 130, 0, 0, 1'b1));
    settle();
    write_reg(crrd_pkg::REG_DETECT_PERCENT, crrd_pkg::CFG_W'(100), 1'b1);
    send_item(pixel(40, 50, 30, 0, 0, 1'b0));
    send_item(pixel(41, 50, 0, 0, 0, 1'b1));
    settle();
    write_reg(crrd_pkg::REG_DETECT_PERCENT, crrd_pkg::CFG_W'(127), 1'b1);
    send_item(pixel(40, 50, 30, 0, 0, 1'b1));
    send_item(pixel(0, 0, 30, 0, 0, 1'b1));         // frame ends outside the area
    settle();
  endtask

  // Rewriting an area register wipes the map but keeps a frame in progress.
  task automatic test_area_change();
    write_reg(crrd_pkg::REG_DETECT_PERCENT, '0, 1'b1);
    send_item(pixel(40, 50, 30, 20, 10, 1'b0));
    settle();
    write_reg(crrd_pkg::REG_AREA_TL, place(10, 20), 1'b1);
    send_item(query(40, 50));
    send_item(pixel(41, 50, 30, 20, 10, 1'b1));
    settle();
  endtask

  // Full-size rectangle, inverted channel bounds, the largest and the
  // smallest radius, and a threshold met exactly.
  task automatic test_extremes();
    load_settings(24'hFFFFFF, 24'h000000, place(0, 0), 24'hFFFFFF, 24'hFFFFFF,
                  4095, 100, 1'b0);
    send_item(pixel(4094, 4094, 255, 255, 255, 1'b0));
    send_item(pixel(4095, 4095, 0, 0, 0, 1'b0));
    send_item(pixel(0, 0, 0, 0, 0, 1'b1));
    settle();
    load_settings(24'h000000, 24'hFFFFFF, place(0, 0), 24'hFFFFFF, place(64, 64),
                  0, 33, 1'b0);
    send_item(pixel(64, 64, 255, 0, 255, 1'b0));
    send_item(pixel(65, 64, 255, 0, 255, 1'b0));
    send_item(pixel(4094, 0, 0, 255, 0, 1'b1));
    send_item(query(64, 64));
    send_item(query(128, 0));
    send_item(query(127, 127));
    send_item(query(4095, 4095));
    settle();
  endtask

  // The receiver holds off for a long stretch while results keep coming,
  // so the block backs up and stalls its input; afterwards the sender waits
  // until every result has been taken.
  task automatic test_backpressure();
    load_settings(24'h0A141E, 24'h6E7882, place(10, 20), place(200, 150),
                  place(40, 50), 10, 0, 1'b0);
    hold_request = 1'b1;
    for (int k = 0; k < 24; k++) begin
      if (k % 2 == 0)
        send_item(query(40 + k, 50));
      else
        send_item(pixel(40 + k, 50, 30 + k, 20 + k, 10 + k, 1'b1));
    end
    settle();
  endtask

  function automatic logic [crrd_pkg::COLOR_W-1:0] pick_channel(
      logic [crrd_pkg::COLOR_W-1:0] lo, logic [crrd_pkg::COLOR_W-1:0] hi);
    case ($urandom_range(0, 3))
      0:       return crrd_pkg::COLOR_W'($urandom_range(0, 255));
      1:       return (lo <= hi) ? crrd_pkg::COLOR_W'($urandom_range(lo, hi)) : lo;
      2:       return crrd_pkg::COLOR_W'(lo + $urandom_range(0, 1) - 1);
      default: return crrd_pkg::COLOR_W'(hi + $urandom_range(0, 1));
    endcase
  endfunction

  // Mostly positions inside the rectangle, often limited to the map window
  // so that queries find written bits; sometimes anywhere at all.
  task automatic pick_pos(output int x, output int y);
    int x0, y0, x1, y1;
    x0 = col_of(rect_tl);
    y0 = row_of(rect_tl);
    x1 = col_of(rect_br);
    y1 = row_of(rect_br);
    if (x1 <= x0 || y1 <= y0 || $urandom_range(0, 7) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
    end else begin
      if ($urandom_range(0, 1)) begin
        if (x1 > x0 + crrd_pkg::MAP_WIDTH + 8) x1 = x0 + crrd_pkg::MAP_WIDTH + 8;
        if (y1 > y0 + crrd_pkg::MAP_HEIGHT + 8) y1 = y0 + crrd_pkg::MAP_HEIGHT + 8;
      end
      x = $urandom_range(x0, x1 - 1);
      y = $urandom_range(y0, y1 - 1);
    end
  endtask

  task automatic random_settings();
    int tlx, tly, brx, bry;
    logic [crrd_pkg::CFG_W-1:0] lo, hi;
    int lo_c, hi_c, rad, pct;
    tlx = $urandom_range(0, 100);
    tly = $urandom_range(0, 100);
    case ($urandom_range(0, 7))
      0: begin                          // the whole coordinate range
        tlx = 0;
        tly = 0;
        brx = 4095;
        bry = 4095;
      end
      1: begin                          // inverted corners, empty area
        brx = $urandom_range(0, tlx);
        bry = $urandom_range(0, 4095);
      end
      default: begin
        brx = tlx + $urandom_range(1, 170);
        bry = tly + $urandom_range(1, 170);
      end
    endcase
    for (int c = 0; c < 3; c++) begin
      lo_c = $urandom_range(0, 200);
      hi_c = $urandom_range(lo_c, 255);
      if ($urandom_range(0, 7) == 0) begin
        lo[8*c +: 8] = crrd_pkg::COLOR_W'(hi_c);
        hi[8*c +: 8] = crrd_pkg::COLOR_W'(lo_c > 0 ? lo_c - 1 : 0);
      end else begin
        lo[8*c +: 8] = crrd_pkg::COLOR_W'(lo_c);
        hi[8*c +: 8] = crrd_pkg::COLOR_W'(hi_c);
      end
    end
    case ($urandom_range(0, 5))
      0:       rad = 0;
      1:       rad = 4095;
      default: rad = $urandom_range(1, 120);
    endcase
    case ($urandom_range(0, 4))
      0:       pct = 0;
      1:       pct = 100;
      2:       pct = $urandom_range(101, 127);
      default: pct = $urandom_range(1, 99);
    endcase
    load_settings(lo, hi, place(tlx, tly), place(brx, bry),
                  place($urandom_range(tlx, tlx + 170), $urandom_range(tly, tly + 170)),
                  rad, pct, 1'($urandom_range(0, 1)));
  endtask

  // Frames of random length with queries mixed in; about one item in ten is
  // completely random, including stray frame ends.
  task automatic random_traffic(input int count);
    crrd_pkg::in_item_t it;
    int sent, flen, x, y;
    sent = 0;
    while (sent < count) begin
      flen = $urandom_range(1, 24);
      for (int k = 0; k < flen; k++) begin
        pick_pos(x, y);
        case ($urandom_range(0, 9))
          0: begin
            it.action    = 1'($urandom_range(0, 1));
            it.red       = crrd_pkg::COLOR_W'($urandom_range(0, 255));
            it.green     = crrd_pkg::COLOR_W'($urandom_range(0, 255));
            it.blue      = crrd_pkg::COLOR_W'($urandom_range(0, 255));
            it.pos_x     = crrd_pkg::POS_W'($urandom_range(0, 4095));
            it.pos_y     = crrd_pkg::POS_W'($urandom_range(0, 4095));
            it.frame_end = 1'($urandom_range(0, 1));
          end
          1, 2: it = query(x, y);
          default: it = pixel(x, y, pick_channel(lo_bounds[7:0], hi_bounds[7:0]),
                              pick_channel(lo_bounds[15:8], hi_bounds[15:8]),
                              pick_channel(lo_bounds[23:16], hi_bounds[23:16]),
                              k == flen - 1);
        endcase
        send_item(it);
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      random_traffic(PHASE_ITEMS);
      settle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // The block sweeps its map after reset; input transfers simply wait
    // for in_ready, so no extra delay is needed here.
    repeat (DRAIN_CYCLES) @(posedge clk);
    test_reset_state();
    test_classification();
    test_gray_and_percent();
    test_area_change();
    test_extremes();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
design/crrd_pkg.sv
design/crrd_map.sv
design/crrd_datapath.sv
design/crrd_ctrl.sv
design/color_range_region_detector_core.sv
tb/sv/color_range_region_detector_core_tb.sv
